// ----- hdl/btc_pkg.sv -----
// Shared types, constants and helper functions of the bone transform chain.
`default_nettype none

package btc_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [6:0]         bone_index;
        logic               has_parent;
        logic [6:0]         parent_index;
        logic signed [15:0] angle_0;
        logic signed [15:0] angle_1;
        logic signed [15:0] angle_2;
        logic signed [31:0] pos_0;
        logic signed [31:0] pos_1;
        logic signed [31:0] pos_2;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] row0_col0;
        logic signed [31:0] row0_col1;
        logic signed [31:0] row0_col2;
        logic signed [31:0] row0_col3;
        logic signed [31:0] row1_col0;
        logic signed [31:0] row1_col1;
        logic signed [31:0] row1_col2;
        logic signed [31:0] row1_col3;
        logic signed [31:0] row2_col0;
        logic signed [31:0] row2_col1;
        logic signed [31:0] row2_col2;
        logic signed [31:0] row2_col3;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
    } sincos_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/btc_cordic.sv -----
// Iterative CORDIC sine and cosine of one binary angle, one step per cycle.
`default_nettype none

module btc_cordic import btc_pkg::*; #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output sincos_t            sc,
    output logic               done
);

    localparam logic [4:0] CNT_LAST = 5'(CORDIC_STEPS - 1);
    localparam int SHIFT = 30 - FRAC_BITS;
    localparam logic signed [33:0] ROUND_Q = 34'sd1 <<< (29 - FRAC_BITS);

    logic signed [33:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [1:0]         q_reg;
    logic [4:0]         cnt_reg;
    logic               run_reg, done_reg;

    logic [31:0] ext, a, a_bias, r;
    logic [1:0]  q;
    logic signed [33:0] sx, sy, rc_full, rs_full;
    logic signed [31:0] rc, rs;

    always_comb
    begin
        ext    = {{16{angle[15]}}, angle};
        a      = {ext[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
        a_bias = a + 32'h2000_0000;
        q      = a_bias[31:30];
        r      = a - {q, 30'd0};
        sx     = x_reg >>> cnt_reg;
        sy     = y_reg >>> cnt_reg;
        rc_full = (x_reg + ROUND_Q) >>> SHIFT;
        rs_full = (y_reg + ROUND_Q) >>> SHIFT;
        rc     = rc_full[31:0];
        rs     = rs_full[31:0];
    end

    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                sc.cos_val = rc;
                sc.sin_val = rs;
            end
            2'd1:
            begin
                sc.cos_val = -rs;
                sc.sin_val = rc;
            end
            2'd2:
            begin
                sc.cos_val = -rc;
                sc.sin_val = -rs;
            end
            default:
            begin
                sc.cos_val = rs;
                sc.sin_val = -rc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= 34'sd0;
            z_reg <= signed'(r);
            q_reg <= q;
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - signed'({2'b00, atan_turn(cnt_reg)});
            end
            else
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + signed'({2'b00, atan_turn(cnt_reg)});
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hdl/btc_mac.sv -----
// Shared 32x32 multiplier with a product register and fixed-point rounding.
`default_nettype none

module btc_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic signed [31:0]        a,
    input  logic signed [31:0]        b,
    output logic signed [63-FRAC_BITS:0] rnd
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;
    logic signed [63:0] sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // Round half up: add half an LSB, then drop the fraction bits.
    assign sum = prod_reg + HALF;
    assign rnd = sum[63:FRAC_BITS];

endmodule

`default_nettype wire

// ----- hdl/bone_transform_chain.sv -----
// Top level: bone table memory, sequencer, CORDIC units and shared multiplier.
//
// Channel   Handshake                Payload
// input     start, busy              item   (in_item_t)
// result    result_valid (strobe)    result (out_item_t)
//
// An item goes through CORDIC (a load and 28 steps, three units in parallel),
// then the local matrix (14 products on the shared multiplier) and, for a child
// bone, the concatenation (39 steps, each a table read, a multiply and a round
// and accumulate); the twelve result words are then written into the table and
// the strobe follows. busy is high from acceptance until the result strobe. The
// result strobe lasts one cycle and cannot be stalled. Reset clears control
// only; the table holds nothing defined until a bone is written.
`default_nettype none

module bone_transform_chain import btc_pkg::*; #(
    parameter int BONE_COUNT = 128,
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      result_valid,
    output out_item_t result
);

    localparam int DEPTH = BONE_COUNT * 12;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = 64 - FRAC_BITS;
    localparam int ACC_W = RW + 2;

    typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_LOCAL, S_CHAIN, S_STORE} state_t;

    state_t state_reg;
    in_item_t item_reg;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] mem_q_reg;
    logic               mem_re, mem_we;
    logic [AW-1:0]      mem_ra, mem_wa;

    sincos_t sc0, sc1, sc2;
    logic    d0, d1, d2;
    logic    accept;

    logic signed [31:0] mac_a, mac_b;
    logic signed [RW-1:0] rnd;

    logic [3:0] op_reg;
    logic [1:0] ph_reg, i_reg, j_reg, k_reg;
    logic [3:0] st_reg;
    logic       rv_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_sum;

    logic signed [31:0] sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg, t1_reg, t2_reg;
    logic signed [33:0] m00_reg, m01_reg, m02_reg, m03_reg;
    logic signed [33:0] m10_reg, m11_reg, m12_reg, m13_reg;
    logic signed [33:0] m20_reg, m21_reg, m22_reg, m23_reg;
    logic signed [31:0] res_reg [12];

    logic signed [33:0] rnd34;
    logic signed [31:0] p_word, mcol;
    logic               parent_ok, bone_ok;
    logic [31:0]        rd_addr, wr_addr;
    logic [1:0]         j_next;

    function automatic logic signed [63:0] ext34(input logic signed [33:0] v);
        return {{30{v[33]}}, v};
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    btc_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic0 (
        .clk(clk), .rst_n(rst_n), .start(accept), .angle(item.angle_0), .sc(sc0), .done(d0)
    );
    btc_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic1 (
        .clk(clk), .rst_n(rst_n), .start(accept), .angle(item.angle_1), .sc(sc1), .done(d1)
    );
    btc_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic2 (
        .clk(clk), .rst_n(rst_n), .start(accept), .angle(item.angle_2), .sc(sc2), .done(d2)
    );

    btc_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .a(mac_a), .b(mac_b), .rnd(rnd)
    );

    always_comb
    begin
        parent_ok = ({25'd0, item_reg.parent_index} < 32'(BONE_COUNT));
        bone_ok   = ({25'd0, item_reg.bone_index} < 32'(BONE_COUNT));
        rd_addr   = {25'd0, item_reg.parent_index} * 32'd12
                    + {28'd0, i_reg, 2'b00} + {30'd0, k_reg};
        wr_addr   = {25'd0, item_reg.bone_index} * 32'd12 + {28'd0, st_reg};
        mem_ra    = rd_addr[AW-1:0];
        mem_wa    = wr_addr[AW-1:0];
        mem_re    = (state_reg == S_CHAIN) && (ph_reg == 2'd0);
        mem_we    = (state_reg == S_STORE) && bone_ok;
        p_word    = parent_ok ? mem_q_reg : 32'sd0;
        rnd34     = rnd[33:0];
        acc_sum   = acc_reg + {{2{rnd[RW-1]}}, rnd};
        j_next    = j_reg + 2'd1;
    end

    always_comb
    begin
        case ({k_reg, j_reg})
            4'b0000: mcol = m00_reg[31:0];
            4'b0001: mcol = m01_reg[31:0];
            4'b0010: mcol = m02_reg[31:0];
            4'b0011: mcol = m03_reg[31:0];
            4'b0100: mcol = m10_reg[31:0];
            4'b0101: mcol = m11_reg[31:0];
            4'b0110: mcol = m12_reg[31:0];
            4'b0111: mcol = m13_reg[31:0];
            4'b1000: mcol = m20_reg[31:0];
            4'b1001: mcol = m21_reg[31:0];
            4'b1010: mcol = m22_reg[31:0];
            4'b1011: mcol = m23_reg[31:0];
            default: mcol = 32'sd0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mac_a = 32'sd0;
        mac_b = 32'sd0;
        if (state_reg == S_CHAIN)
        begin
            mac_a = p_word;
            mac_b = mcol;
        end
        else
        begin
            case (op_reg)
                4'd0:    begin mac_a = sr_reg; mac_b = sp_reg; end
                4'd1:    begin mac_a = cr_reg; mac_b = sp_reg; end
                4'd2:    begin mac_a = cp_reg; mac_b = cy_reg; end
                4'd3:    begin mac_a = t1_reg; mac_b = cy_reg; end
                4'd4:    begin mac_a = cr_reg; mac_b = sy_reg; end
                4'd5:    begin mac_a = t2_reg; mac_b = cy_reg; end
                4'd6:    begin mac_a = sr_reg; mac_b = sy_reg; end
                4'd7:    begin mac_a = cp_reg; mac_b = sy_reg; end
                4'd8:    begin mac_a = t1_reg; mac_b = sy_reg; end
                4'd9:    begin mac_a = cr_reg; mac_b = cy_reg; end
                4'd10:   begin mac_a = t2_reg; mac_b = sy_reg; end
                4'd11:   begin mac_a = sr_reg; mac_b = cy_reg; end
                4'd12:   begin mac_a = sr_reg; mac_b = cp_reg; end
                4'd13:   begin mac_a = cr_reg; mac_b = cp_reg; end
                default: begin mac_a = 32'sd0; mac_b = 32'sd0; end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= res_reg[st_reg];
        if (mem_re)
            mem_q_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            op_reg    <= 4'd0;
            ph_reg    <= 2'd0;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            k_reg     <= 2'd0;
            st_reg    <= 4'd0;
        end
        else
        begin
            rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (d0)
                    begin
                        state_reg <= S_LOCAL;
                        op_reg    <= 4'd0;
                        ph_reg    <= 2'd0;
                    end
                end
                S_LOCAL:
                begin
                    if (ph_reg == 2'd0)
                        ph_reg <= 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        op_reg <= op_reg + 4'd1;
                        if (op_reg == 4'd13)
                        begin
                            i_reg  <= 2'd0;
                            j_reg  <= 2'd0;
                            k_reg  <= 2'd0;
                            st_reg <= 4'd0;
                            state_reg <= item_reg.has_parent ? S_CHAIN : S_STORE;
                        end
                    end
                end
                S_CHAIN:
                begin
                    if (ph_reg != 2'd2)
                        ph_reg <= ph_reg + 2'd1;
                    else
                    begin
                        ph_reg <= 2'd0;
                        if (k_reg == 2'd2)
                        begin
                            j_reg <= j_next;
                            k_reg <= (j_next == 2'd3) ? 2'd3 : 2'd0;
                            if (j_reg == 2'd3)
                            begin
                                i_reg <= i_reg + 2'd1;
                                if (i_reg == 2'd2)
                                    state_reg <= S_STORE;
                            end
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    end
                end
                S_STORE:
                begin
                    st_reg <= st_reg + 4'd1;
                    if (st_reg == 4'd11)
                    begin
                        state_reg <= S_IDLE;
                        rv_reg    <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: item, sines and cosines, local matrix, accumulator, results.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if ((state_reg == S_CORDIC) && d0)
        begin
            sr_reg  <= sc0.sin_val;
            cr_reg  <= sc0.cos_val;
            sp_reg  <= sc1.sin_val;
            cp_reg  <= sc1.cos_val;
            sy_reg  <= sc2.sin_val;
            cy_reg  <= sc2.cos_val;
            m20_reg <= -{{2{sc1.sin_val[31]}}, sc1.sin_val};
            m03_reg <= {{2{item_reg.pos_0[31]}}, item_reg.pos_0};
            m13_reg <= {{2{item_reg.pos_1[31]}}, item_reg.pos_1};
            m23_reg <= {{2{item_reg.pos_2[31]}}, item_reg.pos_2};
        end
        if ((state_reg == S_LOCAL) && (ph_reg == 2'd1))
        begin
            case (op_reg)
                4'd0:    t1_reg  <= rnd[31:0];
                4'd1:    t2_reg  <= rnd[31:0];
                4'd2:    m00_reg <= rnd34;
                4'd3:    m01_reg <= rnd34;
                4'd4:    m01_reg <= m01_reg - rnd34;
                4'd5:    m02_reg <= rnd34;
                4'd6:    m02_reg <= m02_reg + rnd34;
                4'd7:    m10_reg <= rnd34;
                4'd8:    m11_reg <= rnd34;
                4'd9:    m11_reg <= m11_reg + rnd34;
                4'd10:   m12_reg <= rnd34;
                4'd11:   m12_reg <= m12_reg - rnd34;
                4'd12:   m21_reg <= rnd34;
                4'd13:   m22_reg <= rnd34;
                default: t1_reg  <= t1_reg;
            endcase
            // A root bone's result is the local matrix itself.
            if ((op_reg == 4'd13) && !item_reg.has_parent)
            begin
                res_reg[0]  <= sat32(ext34(m00_reg));
                res_reg[1]  <= sat32(ext34(m01_reg));
                res_reg[2]  <= sat32(ext34(m02_reg));
                res_reg[3]  <= sat32(ext34(m03_reg));
                res_reg[4]  <= sat32(ext34(m10_reg));
                res_reg[5]  <= sat32(ext34(m11_reg));
                res_reg[6]  <= sat32(ext34(m12_reg));
                res_reg[7]  <= sat32(ext34(m13_reg));
                res_reg[8]  <= sat32(ext34(m20_reg));
                res_reg[9]  <= sat32(ext34(m21_reg));
                res_reg[10] <= sat32(rnd[63-FRAC_BITS] ? {{(64-RW){1'b1}}, rnd}
                                                       : {{(64-RW){1'b0}}, rnd});
                res_reg[11] <= sat32(ext34(m23_reg));
            end
        end
        if ((state_reg == S_CHAIN) && (ph_reg == 2'd2))
        begin
            // The translation column starts from the parent's own offset.
            if (k_reg == 2'd3)
                acc_reg <= {{(ACC_W-32){p_word[31]}}, p_word};
            else if ((k_reg == 2'd0) && (j_reg != 2'd3))
                acc_reg <= {{2{rnd[RW-1]}}, rnd};
            else
                acc_reg <= acc_sum;
            if (k_reg == 2'd2)
                res_reg[{i_reg, j_reg}] <= sat32({{(64-ACC_W){acc_sum[ACC_W-1]}}, acc_sum});
        end
    end

    assign result_valid     = rv_reg;
    assign result.row0_col0 = res_reg[0];
    assign result.row0_col1 = res_reg[1];
    assign result.row0_col2 = res_reg[2];
    assign result.row0_col3 = res_reg[3];
    assign result.row1_col0 = res_reg[4];
    assign result.row1_col1 = res_reg[5];
    assign result.row1_col2 = res_reg[6];
    assign result.row1_col3 = res_reg[7];
    assign result.row2_col0 = res_reg[8];
    assign result.row2_col1 = res_reg[9];
    assign result.row2_col2 = res_reg[10];
    assign result.row2_col3 = res_reg[11];

    a_cordic_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (d0 == d1) && (d1 == d2))
        else $error("CORDIC units finished out of step");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy did not rise after an accepted item");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_STORE) && !mem_re)
        else $error("table written outside the store sweep");

endmodule

`default_nettype wire
